### rtl/gbe_pkg.sv
// gbe_pkg: shared types and constants for the gap buffer edit engine
// item and result beat structs, operation and screen action codes, store geometry
// no dependencies
package gbe_pkg;

  localparam int unsigned STORE_BYTES = 4096;
  localparam int unsigned ADDR_W      = $clog2(STORE_BYTES);
  localparam int unsigned PTR_W       = $clog2(STORE_BYTES + 1);
  localparam int unsigned CNT_W       = 13;

  localparam logic [7:0] NEWLINE = 8'd10;

  typedef enum logic [1:0] {
    OP_INSERT    = 2'd0,
    OP_BACKSPACE = 2'd1,
    OP_LEFT      = 2'd2,
    OP_RIGHT     = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    ACT_NONE   = 2'd0,
    ACT_RENDER = 2'd1,
    ACT_REDRAW = 2'd2
  } act_e;

  typedef struct packed {
    op_e        func;
    logic [7:0] char_in;
  } in_item_t;

  typedef struct packed {
    logic             applied;
    logic [CNT_W-1:0] cursor_row;
    logic [CNT_W-1:0] cursor_col;
    logic [CNT_W-1:0] line_count;
    logic             modified;
    act_e             screen_action;
  } out_item_t;

  // one write port and one read port per cycle
  typedef struct packed {
    logic              we;
    logic [ADDR_W-1:0] waddr;
    logic [7:0]        wdata;
    logic [ADDR_W-1:0] raddr;
  } mem_req_t;

endpackage

### rtl/gbe_text_ram.sv
// gbe_text_ram: byte store holding the text on both sides of the gap
// one write and one registered read per cycle; uses gbe_pkg
module gbe_text_ram
  import gbe_pkg::*;
(
  input  logic       clk_i,
  input  mem_req_t   req_i,
  output logic [7:0] rdata_o
);

  logic [7:0] mem [STORE_BYTES];
  logic [7:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem[req_i.waddr] <= req_i.wdata;
    end
    rdata_q <= mem[req_i.raddr];
  end

  assign rdata_o = rdata_q;

endmodule

### rtl/gbe_ctrl.sv
// gbe_ctrl: edit sequencer, gap pointers, cursor counters and result register
// drives the text store through a mem_req_t; uses gbe_pkg
module gbe_ctrl
  import gbe_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  in_item_t   in_item_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output out_item_t  out_item_o,
  output mem_req_t   mem_req_o,
  input  logic [7:0] mem_rdata_i
);

  typedef enum logic [4:0] {
    ST_IDLE     = 5'b00001,
    ST_READ     = 5'b00010,
    ST_SCAN_RD  = 5'b00100,
    ST_SCAN_CHK = 5'b01000,
    ST_RESP     = 5'b10000
  } state_e;

  state_e           state_q, state_d;
  logic [PTR_W-1:0] gb_q, gb_d, gf_q, gf_d, idx_q, idx_d;
  logic [CNT_W-1:0] row_q, row_d, col_q, col_d, lines_q, lines_d;
  logic             mod_q, mod_d;
  op_e              op_q, op_d;
  logic             applied_q, applied_d;
  act_e             action_q, action_d;
  logic             out_valid_q, out_valid_d;
  out_item_t        out_item_q, out_item_d;

  logic [PTR_W-1:0] gb_dec, gf_dec, idx_dec;
  logic             is_nl;

  assign gb_dec  = gb_q - PTR_W'(1);
  assign gf_dec  = gf_q - PTR_W'(1);
  assign idx_dec = idx_q - PTR_W'(1);
  assign is_nl   = (mem_rdata_i == NEWLINE);

  always_comb begin
    state_d     = state_q;
    gb_d        = gb_q;
    gf_d        = gf_q;
    idx_d       = idx_q;
    row_d       = row_q;
    col_d       = col_q;
    lines_d     = lines_q;
    mod_d       = mod_q;
    op_d        = op_q;
    applied_d   = applied_q;
    action_d    = action_q;
    out_valid_d = out_valid_q;
    out_item_d  = out_item_q;

    mem_req_o.we    = 1'b0;
    mem_req_o.waddr = gb_q[ADDR_W-1:0];
    mem_req_o.wdata = in_item_i.char_in;
    mem_req_o.raddr = gb_dec[ADDR_W-1:0];

    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          op_d      = in_item_i.func;
          applied_d = 1'b0;
          action_d  = ACT_NONE;
          state_d   = ST_RESP;
          case (in_item_i.func)
            OP_INSERT: begin
              if (gb_q < gf_q) begin
                mem_req_o.we = 1'b1;
                gb_d         = gb_q + PTR_W'(1);
                if (in_item_i.char_in == NEWLINE) begin
                  lines_d = lines_q + CNT_W'(1);
                  row_d   = row_q + CNT_W'(1);
                  col_d   = '0;
                end else begin
                  col_d = col_q + CNT_W'(1);
                end
                action_d  = mod_q ? ACT_REDRAW : ACT_RENDER;
                mod_d     = 1'b1;
                applied_d = 1'b1;
              end
            end
            OP_BACKSPACE, OP_LEFT: begin
              if (gb_q != '0) begin
                mem_req_o.raddr = gb_dec[ADDR_W-1:0];
                state_d         = ST_READ;
              end
            end
            OP_RIGHT: begin
              if (gf_q != PTR_W'(STORE_BYTES)) begin
                mem_req_o.raddr = gf_q[ADDR_W-1:0];
                state_d         = ST_READ;
              end
            end
            default: ;
          endcase
        end
      end

      ST_READ: begin
        applied_d = 1'b1;
        state_d   = ST_RESP;
        idx_d     = gb_dec;
        if (op_q == OP_RIGHT) begin
          mem_req_o.we    = 1'b1;
          mem_req_o.waddr = gb_q[ADDR_W-1:0];
          mem_req_o.wdata = mem_rdata_i;
          gb_d            = gb_q + PTR_W'(1);
          gf_d            = gf_q + PTR_W'(1);
          if (is_nl) begin
            row_d = row_q + CNT_W'(1);
            col_d = '0;
          end else begin
            col_d = col_q + CNT_W'(1);
          end
        end else begin
          gb_d = gb_dec;
          if (op_q == OP_LEFT) begin
            mem_req_o.we    = 1'b1;
            mem_req_o.waddr = gf_dec[ADDR_W-1:0];
            mem_req_o.wdata = mem_rdata_i;
            gf_d            = gf_dec;
          end else begin
            action_d = (mod_q && !is_nl) ? ACT_REDRAW : ACT_RENDER;
            mod_d    = 1'b1;
            if (is_nl && lines_q > CNT_W'(1)) begin
              lines_d = lines_q - CNT_W'(1);
            end
          end
          if (is_nl) begin
            // moved up a line: column comes from the scan back to the previous newline
            if (row_q != '0) begin
              row_d = row_q - CNT_W'(1);
            end
            state_d = ST_SCAN_RD;
          end else if (col_q != '0) begin
            col_d = col_q - CNT_W'(1);
          end
        end
      end

      ST_SCAN_RD: begin
        mem_req_o.raddr = idx_dec[ADDR_W-1:0];
        if (idx_q == '0) begin
          col_d   = CNT_W'(gb_q - idx_q);
          state_d = ST_RESP;
        end else begin
          state_d = ST_SCAN_CHK;
        end
      end

      ST_SCAN_CHK: begin
        if (is_nl) begin
          col_d   = CNT_W'(gb_q - idx_q);
          state_d = ST_RESP;
        end else begin
          idx_d   = idx_dec;
          state_d = ST_SCAN_RD;
        end
      end

      ST_RESP: begin
        // hold until the result register is free
        if (!out_valid_q || !out_stall_i) begin
          out_valid_d              = 1'b1;
          out_item_d.applied       = applied_q;
          out_item_d.cursor_row    = row_q;
          out_item_d.cursor_col    = col_q;
          out_item_d.line_count    = lines_q;
          out_item_d.modified      = mod_q;
          out_item_d.screen_action = action_q;
          state_d                  = ST_IDLE;
        end
      end

      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      gb_q        <= '0;
      gf_q        <= PTR_W'(STORE_BYTES);
      row_q       <= '0;
      col_q       <= '0;
      lines_q     <= CNT_W'(1);
      mod_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      gb_q        <= gb_d;
      gf_q        <= gf_d;
      row_q       <= row_d;
      col_q       <= col_d;
      lines_q     <= lines_d;
      mod_q       <= mod_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q       <= op_d;
    idx_q      <= idx_d;
    applied_q  <= applied_d;
    action_q   <= action_d;
    out_item_q <= out_item_d;
  end

  assign in_stall_o  = (state_q != ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

endmodule

### rtl/gap_buffer_edit_engine_top.sv
// Gap buffer edit engine: a text gap buffer in a single-port-read byte store with
// cursor row/column, line count and modified tracking. One result beat per input
// beat. An insert or a refused operation goes from accept straight to the result
// state; a backspace, left or right move first reads the byte beside the gap from
// the store. A backspace or left move over a newline then scans back to the
// previous newline one store read at a time, stopping there or at the start of
// the store.
// The input is stalled while an operation is in flight; a finished result sits in
// the output register, and the next beat may be accepted while it waits.
// Depends on gbe_pkg, gbe_text_ram and gbe_ctrl.
module gap_buffer_edit_engine_top
  import gbe_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  in_item_t  in_item_i,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output out_item_t out_item_o
);

  mem_req_t   mem_req;
  logic [7:0] mem_rdata;

  gbe_text_ram u_text_ram (
    .clk_i   (clk_i),
    .req_i   (mem_req),
    .rdata_o (mem_rdata)
  );

  gbe_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_item_i   (in_item_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_item_o  (out_item_o),
    .mem_req_o   (mem_req),
    .mem_rdata_i (mem_rdata)
  );

endmodule
